### rtl/core/qlte_pkg.sv
// qlte_pkg: shared constants, types and control store for the q-learning table engine
package qlte_pkg;

  localparam int NUM_STATES  = 64;
  localparam int NUM_ACTIONS = 4;
  localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;

  localparam int ROW_W  = $clog2(NUM_STATES);
  localparam int COL_W  = $clog2(NUM_ACTIONS);
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int Q_W        = 24;
  localparam int STATE_IN_W = 6;
  localparam int ACT_IN_W   = 2;
  localparam int DRAW_W     = 16;
  localparam int RATE_W     = 16;
  localparam int EPS_W      = 17;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_THRESH  = 2'd2;

  localparam logic [RATE_W-1:0] LEARNING_RATE_RST   = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_FACTOR_RST = 16'd58982;
  localparam logic [EPS_W-1:0]  EXPLORE_THRESH_RST  = 17'd6554;

  localparam logic OP_CHOOSE = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // arithmetic widths
  localparam int DIFF_W = Q_W + 1;
  localparam int GM_W   = RATE_W + 1 + Q_W;
  localparam int T_W    = DIFF_W + RATE_W + 1;
  localparam int TLO_W  = T_W / 2;
  localparam int THI_W  = T_W - TLO_W;
  localparam int PL_W   = RATE_W + TLO_W;
  localparam int PH_W   = RATE_W + 1 + THI_W;
  localparam int P_W    = PH_W + TLO_W + 1;
  localparam int D_W    = P_W - 32;
  localparam int NV_W   = D_W + 1;

  localparam logic signed [NV_W-1:0] QMAX = NV_W'(8388607);
  localparam logic signed [NV_W-1:0] QMIN = -NV_W'(8388608);

  // control store
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_CLR   = 4'd0;
  localparam upc_t UPC_IDLE  = 4'd1;
  localparam upc_t UPC_SCAN  = 4'd2;
  localparam upc_t UPC_LAST  = 4'd3;
  localparam upc_t UPC_DIFF  = 4'd4;
  localparam upc_t UPC_TSUM  = 4'd5;
  localparam upc_t UPC_MULA  = 4'd6;
  localparam upc_t UPC_PSUM  = 4'd7;
  localparam upc_t UPC_CLAMP = 4'd8;
  localparam upc_t UPC_RES   = 4'd9;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_WAIT_CLR,
    SEQ_WAIT_IN,
    SEQ_LOOP_SCAN,
    SEQ_BR_CHOOSE,
    SEQ_WAIT_OUT
  } seq_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SCAN,
    RD_OLD
  } rd_t;

  typedef enum logic [1:0] {
    CMP_NONE,
    CMP_PREV,
    CMP_CUR
  } cmp_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_DIFF,
    DP_TSUM,
    DP_MULA,
    DP_PSUM,
    DP_CLAMP
  } dp_t;

  typedef struct packed {
    seq_t seq;
    upc_t target;
    rd_t  rd;
    cmp_t cmp;
    dp_t  dp;
    logic clr_wr;
    logic in_rdy;
    logic out_ld;
  } ucode_t;

  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    w        = '0;
    w.seq    = SEQ_NEXT;
    w.target = UPC_IDLE;
    w.rd     = RD_NONE;
    w.cmp    = CMP_NONE;
    w.dp     = DP_NONE;
    unique case (a)
      UPC_CLR: begin
        w.seq    = SEQ_WAIT_CLR;
        w.clr_wr = 1'b1;
      end
      UPC_IDLE: begin
        w.seq    = SEQ_WAIT_IN;
        w.target = UPC_RES;
        w.in_rdy = 1'b1;
      end
      UPC_SCAN: begin
        w.seq = SEQ_LOOP_SCAN;
        w.rd  = RD_SCAN;
        w.cmp = CMP_PREV;
      end
      UPC_LAST: begin
        w.seq    = SEQ_BR_CHOOSE;
        w.target = UPC_RES;
        w.rd     = RD_OLD;
        w.cmp    = CMP_CUR;
      end
      UPC_DIFF:  w.dp = DP_DIFF;
      UPC_TSUM:  w.dp = DP_TSUM;
      UPC_MULA:  w.dp = DP_MULA;
      UPC_PSUM:  w.dp = DP_PSUM;
      UPC_CLAMP: w.dp = DP_CLAMP;
      UPC_RES: begin
        w.seq    = SEQ_WAIT_OUT;
        w.target = UPC_IDLE;
        w.out_ld = 1'b1;
      end
      default: begin
        w.seq    = SEQ_JUMP;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  // reduce a small index modulo m by restoring subtraction
  function automatic int wrap_index(int v, int m);
    int r;
    r = v;
    for (int k = STATE_IN_W - 1; k >= 0; k--) begin
      if ((m << k) <= r) begin
        r = r - (m << k);
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/q_learning_table_engine.sv
// q_learning_table_engine: microcoded q-table engine with epsilon-greedy choice and update
//
//  ch  | handshake           | fields
//  ----+---------------------+------------------------------------------------------------
//  in  | in_valid in_ready   | op state_index action reward next_state random_draw random_action
//  out | out_valid out_ready | chosen_action explored updated_value saturated
//  cfg | cfg_write_en        | cfg_index cfg_data
//
// explore choose skips the row scan, greedy choose scans the state row, update scans the next-state row: one table
// read a cycle for the row scan and the old entry, then five arithmetic steps ending in write-back
// after reset the table is cleared one entry a cycle, all NUM_STATES*NUM_ACTIONS entries,
// before in_ready rises
// a new item is taken while the last result waits; the program holds in its result step
// until the output register is free
module q_learning_table_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic [qlte_pkg::STATE_IN_W-1:0]      state_index,
  input  logic [qlte_pkg::ACT_IN_W-1:0]        action,
  input  logic signed [qlte_pkg::Q_W-1:0]      reward,
  input  logic [qlte_pkg::STATE_IN_W-1:0]      next_state,
  input  logic [qlte_pkg::DRAW_W-1:0]          random_draw,
  input  logic [qlte_pkg::ACT_IN_W-1:0]        random_action,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [qlte_pkg::ACT_IN_W-1:0]        chosen_action,
  output logic                                 explored,
  output logic signed [qlte_pkg::Q_W-1:0]      updated_value,
  output logic                                 saturated,
  input  logic                                 cfg_write_en,
  input  logic [qlte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qlte_pkg::CFG_W-1:0]           cfg_data
);
  import qlte_pkg::*;

  logic [RATE_W-1:0] learning_rate;
  logic [RATE_W-1:0] discount_factor;
  logic [EPS_W-1:0]  exploration_threshold;

  upc_t   upc;
  upc_t   upc_next;
  ucode_t cw;

  logic              accept;
  logic              explore_now;
  logic              out_free;

  logic              op_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  nrow_q;
  logic [COL_W-1:0]  ract_q;
  logic              explore_q;
  logic signed [Q_W-1:0] reward_q;

  logic [COL_W-1:0]  cnt;
  logic              cnt_last;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_last;

  logic signed [Q_W-1:0] mem [DEPTH];
  logic signed [Q_W-1:0] rd_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  wr_en;
  logic signed [Q_W-1:0] wr_data;
  logic [ROW_W-1:0]      scan_row;

  logic                  cmp_en;
  logic [COL_W-1:0]      cmp_col;
  logic signed [Q_W-1:0] best;
  logic [COL_W-1:0]      best_col;

  logic signed [Q_W-1:0]    old_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [GM_W-1:0]   gm_q;
  logic signed [T_W-1:0]    t_q;
  logic [PL_W-1:0]          pl_q;
  logic signed [PH_W-1:0]   ph_q;
  logic signed [D_W-1:0]    d_q;
  logic signed [P_W-1:0]    p_sum;
  logic signed [NV_W-1:0]   nv;
  logic signed [Q_W-1:0]    nv_clamped;
  logic                     nv_sat;
  logic signed [Q_W-1:0]    new_q;
  logic                     sat_q;

  logic [COL_W+ACT_IN_W-1:0] pick_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate         <= LEARNING_RATE_RST;
      discount_factor       <= DISCOUNT_FACTOR_RST;
      exploration_threshold <= EXPLORE_THRESH_RST;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_LEARNING_RATE) begin
        learning_rate <= cfg_data[RATE_W-1:0];
      end
      if (cfg_index == REG_DISCOUNT_FACTOR) begin
        discount_factor <= cfg_data[RATE_W-1:0];
      end
      if (cfg_index == REG_EXPLORE_THRESH) begin
        exploration_threshold <= cfg_data[EPS_W-1:0];
      end
    end
  end

  // control word decode
  always_comb begin
    cw = ucode_rom(upc);
  end

  assign in_ready    = cw.in_rdy;
  assign accept      = in_valid && in_ready;
  assign explore_now = ({1'b0, random_draw} < exploration_threshold);
  assign out_free    = !out_valid || out_ready;
  assign cnt_last    = (cnt == COL_W'(NUM_ACTIONS - 1));
  assign clr_last    = (clr_addr == ADDR_W'(DEPTH - 1));

  // sequencer
  always_comb begin
    upc_next = upc;
    unique case (cw.seq)
      SEQ_NEXT:      upc_next = upc + 1'b1;
      SEQ_JUMP:      upc_next = cw.target;
      SEQ_WAIT_CLR:  upc_next = clr_last ? upc + 1'b1 : upc;
      SEQ_WAIT_IN: begin
        if (accept) begin
          upc_next = (op == OP_CHOOSE && explore_now) ? cw.target : upc + 1'b1;
        end
      end
      SEQ_LOOP_SCAN: upc_next = cnt_last ? upc + 1'b1 : upc;
      SEQ_BR_CHOOSE: upc_next = (op_q == OP_CHOOSE) ? cw.target : upc + 1'b1;
      SEQ_WAIT_OUT:  upc_next = out_free ? cw.target : upc;
      default:       upc_next = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc      <= UPC_CLR;
      clr_addr <= '0;
    end else begin
      upc <= upc_next;
      if (cw.clr_wr && !clr_last) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op;
      row_q     <= ROW_W'(wrap_index(int'(state_index), NUM_STATES));
      nrow_q    <= ROW_W'(wrap_index(int'(next_state), NUM_STATES));
      col_q     <= COL_W'(wrap_index(int'(action), NUM_ACTIONS));
      ract_q    <= COL_W'(wrap_index(int'(random_action), NUM_ACTIONS));
      reward_q  <= reward;
      explore_q <= (op == OP_CHOOSE) && explore_now;
    end
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
    end else if (cw.seq == SEQ_LOOP_SCAN && !cnt_last) begin
      cnt <= cnt + 1'b1;
    end
  end

  // table port selection
  assign scan_row = (op_q == OP_UPDATE) ? nrow_q : row_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (cw.rd)
      RD_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(scan_row) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(cnt);
      end
      RD_OLD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(row_q) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(col_q);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  assign wr_en   = cw.clr_wr || (cw.dp == DP_CLAMP);
  assign wr_addr = cw.clr_wr ? clr_addr
                             : ADDR_W'(row_q) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(col_q);
  assign wr_data = cw.clr_wr ? '0 : nv_clamped;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // row maximum, ties keep the lowest column
  always_comb begin
    cmp_en  = 1'b0;
    cmp_col = cnt;
    unique case (cw.cmp)
      CMP_PREV: begin
        cmp_en  = (cnt != '0);
        cmp_col = cnt - 1'b1;
      end
      CMP_CUR: begin
        cmp_en  = 1'b1;
        cmp_col = cnt;
      end
      default: begin
        cmp_en  = 1'b0;
        cmp_col = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmp_en && (cmp_col == '0 || rd_data > best)) begin
      best     <= rd_data;
      best_col <= cmp_col;
    end
  end

  // update arithmetic
  assign p_sum = (P_W'(ph_q) <<< TLO_W) + P_W'($signed({1'b0, pl_q}))
               + (P_W'(1) <<< 31);
  assign nv    = NV_W'(old_q) + NV_W'(d_q);

  always_comb begin
    nv_sat     = 1'b0;
    nv_clamped = nv[Q_W-1:0];
    if (nv > QMAX) begin
      nv_sat     = 1'b1;
      nv_clamped = QMAX[Q_W-1:0];
    end else if (nv < QMIN) begin
      nv_sat     = 1'b1;
      nv_clamped = QMIN[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.dp)
      DP_DIFF: begin
        old_q  <= rd_data;
        diff_q <= DIFF_W'(reward_q) - DIFF_W'(rd_data);
        gm_q   <= $signed({1'b0, discount_factor}) * best;
      end
      DP_TSUM: begin
        t_q <= (T_W'(diff_q) <<< RATE_W) + T_W'(gm_q);
      end
      DP_MULA: begin
        pl_q <= PL_W'(learning_rate) * PL_W'(t_q[TLO_W-1:0]);
        ph_q <= $signed({1'b0, learning_rate}) * $signed(t_q[T_W-1:TLO_W]);
      end
      DP_PSUM: begin
        d_q <= p_sum[P_W-1:32];
      end
      DP_CLAMP: begin
        new_q <= nv_clamped;
        sat_q <= nv_sat;
      end
      default: begin
      end
    endcase
  end

  // output register
  assign pick_ext = explore_q ? {{ACT_IN_W{1'b0}}, ract_q} : {{ACT_IN_W{1'b0}}, best_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.out_ld && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.out_ld && out_free) begin
      if (op_q == OP_UPDATE) begin
        chosen_action <= '0;
        explored      <= 1'b0;
        updated_value <= new_q;
        saturated     <= sat_q;
      end else begin
        chosen_action <= pick_ext[ACT_IN_W-1:0];
        explored      <= explore_q;
        updated_value <= '0;
        saturated     <= 1'b0;
      end
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (upc == UPC_CLR) |-> !in_ready)
    else $error("item taken while table clear runs");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (upc != UPC_IDLE))
    else $error("sequencer stayed idle after transfer");

  a_explore_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && explored) |-> (updated_value == '0 && !saturated))
    else $error("explore result carries an update value");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (updated_value == QMAX[Q_W-1:0] || updated_value == QMIN[Q_W-1:0]))
    else $error("saturated value not at a limit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (upc == UPC_SCAN) |-> (cnt <= COL_W'(NUM_ACTIONS - 1)))
    else $error("scan column out of range");

endmodule
